// ===== rtl/c3lb_pkg.sv =====
package c3lb_pkg;

	localparam int MAX_WIDTH = 128;
	localparam int MAX_HEIGHT = 128;
	localparam int MIN_SIZE = 3;
	localparam int SIZE_W = 8;
	localparam int PIX_W = 8;
	localparam int COEF_W = 8;
	localparam int PROD_W = 16;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int PC_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int TOTAL_W = PC_W + 1;
	localparam int PIX_MAX = 255;
	localparam int OUT_FIFO_DEPTH = 8;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int COEF_ROW_W = 24;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [PROD_W-1:0] acc_t;

	typedef enum logic [2:0] {
		REG_WIDTH  = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_COEF0  = 3'd2,
		REG_COEF1  = 3'd3,
		REG_COEF2  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic valid;
		logic emit;
		logic last;
	} tag_t;

	typedef struct packed {
		pix_t pixel;
		logic last;
	} result_t;

	function automatic logic [SIZE_W-1:0] sat_size(logic [SIZE_W-1:0] v,
		logic [SIZE_W-1:0] hi);
		logic [SIZE_W-1:0] r;
		if (v < SIZE_W'(MIN_SIZE)) begin
			r = SIZE_W'(MIN_SIZE);
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ===== rtl/c3lb_ram.sv =====
module c3lb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/c3lb_cell.sv =====
module c3lb_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift_en,
	input  c3lb_pkg::pix_t  pix_in,
	input  c3lb_pkg::coef_t coef,
	output c3lb_pkg::pix_t  pix,
	output c3lb_pkg::acc_t  prod
);

	c3lb_pkg::pix_t pix_q;
	c3lb_pkg::acc_t prod_s2;
	logic signed [c3lb_pkg::PIX_W+c3lb_pkg::COEF_W:0] full_prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q <= '0;
		end else if (shift_en) begin
			pix_q <= pix_in;
		end
	end

	// The pixel is unsigned, so it gets a zero sign bit before the signed multiply.
	assign full_prod = $signed({1'b0, pix_q}) * coef;

	always_ff @(posedge clk) begin
		prod_s2 <= full_prod[c3lb_pkg::PROD_W-1:0];
	end

	assign pix = pix_q;
	assign prod = prod_s2;

endmodule

// ===== rtl/c3lb_out_fifo.sv =====
module c3lb_out_fifo (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      push,
	input  c3lb_pkg::result_t                         push_data,
	input  logic                                      pop,
	output c3lb_pkg::result_t                         pop_data,
	output logic                                      not_empty,
	output logic [$clog2(c3lb_pkg::OUT_FIFO_DEPTH):0] count
);

	localparam int AW = $clog2(c3lb_pkg::OUT_FIFO_DEPTH);

	c3lb_pkg::result_t mem_q [0:c3lb_pkg::OUT_FIFO_DEPTH-1];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;
	logic          do_pop;

	assign not_empty = (count_q != '0);
	assign do_pop = pop && not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign pop_data = mem_q[rd_ptr_q];
	assign count = count_q;

endmodule

// ===== rtl/conv3x3_line_buffer_filter.sv =====
// 3x3 convolution over a raster pixel stream. One pixel is accepted per clock
// cycle while in_stall is low. Each completed window passes through line store
// read, window shift, nine multipliers, row sums, final sum and clamp, and its
// filtered pixel leaves through an eight-entry output queue. in_stall rises
// only when that queue plus the items in flight could fill it, so a short
// out_stall does not reach the input. The two previous lines are kept in a
// 128-row RAM whose rows carry valid bits, so a row never written reads as zero
// right after reset. Frame size and coefficients are to be written over the APB
// port while no item is in flight (not enforced); mid-frame writes keep the counters.
module conv3x3_line_buffer_filter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    in_pixel,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    out_pixel,
	output logic                          frame_last,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [c3lb_pkg::ADDR_W-1:0]   paddr,
	input  logic [c3lb_pkg::DATA_W-1:0]   pwdata,
	output logic [c3lb_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int SW = c3lb_pkg::SIZE_W;
	localparam int TW = c3lb_pkg::TOTAL_W;
	localparam int CW = c3lb_pkg::COL_W;
	localparam int PW = c3lb_pkg::PC_W;
	localparam int FCW = $clog2(c3lb_pkg::OUT_FIFO_DEPTH) + 1;

	// Configuration registers.
	logic [SW-1:0] width_q;
	logic [SW-1:0] height_q;
	logic [c3lb_pkg::COEF_ROW_W-1:0] coef_q [0:2];
	logic cfg_wr;
	c3lb_pkg::reg_idx_t cfg_idx;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign cfg_idx = c3lb_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= SW'(c3lb_pkg::MAX_WIDTH);
			height_q <= SW'(c3lb_pkg::MAX_HEIGHT);
			coef_q[0] <= '0;
			coef_q[1] <= '0;
			coef_q[2] <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				c3lb_pkg::REG_WIDTH: width_q <= pwdata[SW-1:0];
				c3lb_pkg::REG_HEIGHT: height_q <= pwdata[SW-1:0];
				c3lb_pkg::REG_COEF0: coef_q[0] <= pwdata[c3lb_pkg::COEF_ROW_W-1:0];
				c3lb_pkg::REG_COEF1: coef_q[1] <= pwdata[c3lb_pkg::COEF_ROW_W-1:0];
				c3lb_pkg::REG_COEF2: coef_q[2] <= pwdata[c3lb_pkg::COEF_ROW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			c3lb_pkg::REG_WIDTH: prdata = c3lb_pkg::DATA_W'(width_q);
			c3lb_pkg::REG_HEIGHT: prdata = c3lb_pkg::DATA_W'(height_q);
			c3lb_pkg::REG_COEF0: prdata = c3lb_pkg::DATA_W'(coef_q[0]);
			c3lb_pkg::REG_COEF1: prdata = c3lb_pkg::DATA_W'(coef_q[1]);
			c3lb_pkg::REG_COEF2: prdata = c3lb_pkg::DATA_W'(coef_q[2]);
			default: prdata = '0;
		endcase
	end

	// Frame position. Counters left beyond a new, smaller size restart at zero.
	logic [SW-1:0] w_eff;
	logic [SW-1:0] h_eff;
	logic [TW-1:0] total;
	logic [TW-1:0] pc_eff;
	logic [CW-1:0] col_eff;
	logic [CW-1:0] col_next;
	logic [CW-1:0] col_q;
	logic [PW-1:0] pc_q;
	logic          is_last;
	logic          is_emit;
	logic          in_acc;

	assign w_eff = c3lb_pkg::sat_size(width_q, SW'(c3lb_pkg::MAX_WIDTH));
	assign h_eff = c3lb_pkg::sat_size(height_q, SW'(c3lb_pkg::MAX_HEIGHT));
	assign total = TW'(w_eff) * TW'(h_eff);
	assign pc_eff = (TW'(pc_q) >= total) ? '0 : TW'(pc_q);
	assign col_eff = (SW'(col_q) >= w_eff) ? '0 : col_q;
	assign col_next = (SW'(col_eff) == w_eff - 1'b1) ? '0 : col_eff + 1'b1;
	assign is_last = (pc_eff == total - 1'b1);
	assign is_emit = (pc_eff >= (TW'(w_eff) << 1) + TW'(2)) && (col_eff > CW'(1));
	assign in_acc = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			pc_q <= '0;
		end else if (in_acc) begin
			if (is_last) begin
				col_q <= '0;
				pc_q <= '0;
			end else begin
				col_q <= col_next;
				pc_q <= pc_eff[PW-1:0] + 1'b1;
			end
		end
	end

	// Pipeline tags and payload.
	c3lb_pkg::tag_t tag_s1, tag_s2, tag_s3, tag_s4;
	c3lb_pkg::pix_t px_s1;
	logic [CW-1:0]  col_s1;
	logic           row_ok_s1;
	logic [c3lb_pkg::MAX_WIDTH-1:0] row_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			row_valid_q <= '0;
		end else begin
			tag_s1 <= '{valid: in_acc, emit: is_emit, last: is_last};
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			if (tag_s1.valid) begin
				row_valid_q[col_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			px_s1 <= in_pixel;
			col_s1 <= col_eff;
			row_ok_s1 <= row_valid_q[col_eff];
		end
	end

	// Line store: low byte is the older line, high byte the newer one.
	logic [2*c3lb_pkg::PIX_W-1:0] ram_rdata;
	c3lb_pkg::pix_t top_pix;
	c3lb_pkg::pix_t mid_pix;

	c3lb_ram #(
		.WIDTH(2 * c3lb_pkg::PIX_W),
		.DEPTH(c3lb_pkg::MAX_WIDTH)
	) u_line_ram (
		.clk(clk),
		.we(tag_s1.valid),
		.waddr(col_s1),
		.wdata({px_s1, mid_pix}),
		.raddr(col_eff),
		.rdata(ram_rdata)
	);

	assign top_pix = row_ok_s1 ? ram_rdata[c3lb_pkg::PIX_W-1:0] : '0;
	assign mid_pix = row_ok_s1 ? ram_rdata[2*c3lb_pkg::PIX_W-1:c3lb_pkg::PIX_W] : '0;

	// Window: three rows of three cells, each shifting toward column 0.
	c3lb_pkg::pix_t new_pix [0:2];
	c3lb_pkg::pix_t win_pix [0:8];
	c3lb_pkg::acc_t prod [0:8];

	assign new_pix[0] = top_pix;
	assign new_pix[1] = mid_pix;
	assign new_pix[2] = px_s1;

	for (genvar r = 0; r < 3; r++) begin : g_row
		for (genvar c = 0; c < 3; c++) begin : g_col
			c3lb_pkg::pix_t cell_in;
			if (c == 2) begin : g_newest
				assign cell_in = new_pix[r];
			end else begin : g_older
				assign cell_in = win_pix[r*3+c+1];
			end
			c3lb_cell u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.shift_en(tag_s1.valid),
				.pix_in(cell_in),
				.coef(coef_q[r][c*c3lb_pkg::COEF_W +: c3lb_pkg::COEF_W]),
				.pix(win_pix[r*3+c]),
				.prod(prod[r*3+c])
			);
		end
	end

	// Sum wraps at 16 bits, then clamps to a byte.
	c3lb_pkg::acc_t row_sum_s3 [0:2];
	c3lb_pkg::acc_t full_sum;
	c3lb_pkg::pix_t out_pix;

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			row_sum_s3[r] <= prod[r*3] + prod[r*3+1] + prod[r*3+2];
		end
	end

	assign full_sum = row_sum_s3[0] + row_sum_s3[1] + row_sum_s3[2];

	// The clamped pixel goes straight into the queue in the same cycle as its tag.
	always_comb begin
		if (full_sum[c3lb_pkg::PROD_W-1]) begin
			out_pix = '0;
		end else if (full_sum > c3lb_pkg::acc_t'(c3lb_pkg::PIX_MAX)) begin
			out_pix = c3lb_pkg::PIX_W'(c3lb_pkg::PIX_MAX);
		end else begin
			out_pix = full_sum[c3lb_pkg::PIX_W-1:0];
		end
	end

	// Output queue with credit: every item in flight holds one entry.
	c3lb_pkg::result_t fifo_in;
	c3lb_pkg::result_t fifo_out;
	logic [FCW-1:0] fifo_count;
	logic [2:0]     inflight;
	logic           fifo_push;

	assign fifo_push = tag_s4.valid && tag_s4.emit;
	assign fifo_in = '{pixel: out_pix, last: tag_s4.last};
	assign inflight = 3'(tag_s1.valid) + 3'(tag_s2.valid) + 3'(tag_s3.valid)
		+ 3'(tag_s4.valid);
	assign in_stall = ((FCW+1)'(fifo_count) + (FCW+1)'(inflight))
		>= (FCW+1)'(c3lb_pkg::OUT_FIFO_DEPTH);

	c3lb_out_fifo u_out_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(fifo_push),
		.push_data(fifo_in),
		.pop(!out_stall),
		.pop_data(fifo_out),
		.not_empty(out_valid),
		.count(fifo_count)
	);

	assign out_pixel = fifo_out.pixel;
	assign frame_last = fifo_out.last;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		((FCW+1)'(fifo_count) + (FCW+1)'(inflight))
			<= (FCW+1)'(c3lb_pkg::OUT_FIFO_DEPTH))
		else $error("output queue credit exceeded");

	a_row_marked: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s1.valid |=> row_valid_q[$past(col_s1)])
		else $error("line store row not marked valid after write");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(tag_s1.valid && tag_s1.last) |-> (pc_q == '0 && col_q == '0))
		else $error("counters not cleared after last pixel of frame");

	a_emit_column: assert property (@(posedge clk) disable iff (!arst_n)
		(tag_s1.valid && tag_s1.emit) |-> (col_s1 > CW'(1)))
		else $error("result scheduled at a column below two");

endmodule
